@@ sv/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants for the positional list store
// Word formats, command and status codes, and the cell control group.
// ----------------------------------------------------------------------------
package plst_pkg;

  // Default list depth
  localparam int unsigned CapacityDef = 16;

  // Fixed field widths
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Input word
  typedef struct packed {
    cmd_e                   command;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value;
  } in_t;

  // Result word
  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] removed_value;
    logic [CountW-1:0]      count;
    logic signed [ValW-1:0] first_value;
    logic signed [ValW-1:0] last_value;
  } out_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // accepted insert that succeeds
    logic rem;  // accepted remove that succeeds
  } cell_ctrl_t;

endpackage

@@ sv/plst_cell.sv @@
// ----------------------------------------------------------------------------
// plst_cell: one slot of the list
// Holds one entry and shifts it toward or away from its neighbors when an
// insert or remove lands at or ahead of this slot.
// ----------------------------------------------------------------------------
module plst_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CMPW = 7
) (
  input  logic                               clk_i,
  input  plst_pkg::cell_ctrl_t               ctrl_i,
  input  logic [CMPW-1:0]                    pos_i,
  input  logic [CMPW-1:0]                    cnt_i,
  input  logic signed [plst_pkg::ValW-1:0]   value_i,
  input  logic signed [plst_pkg::ValW-1:0]   left_i,
  input  logic signed [plst_pkg::ValW-1:0]   right_i,
  input  logic signed [plst_pkg::ValW-1:0]   rm_chain_i,
  input  logic signed [plst_pkg::ValW-1:0]   last_chain_i,
  output logic signed [plst_pkg::ValW-1:0]   value_o,
  output logic signed [plst_pkg::ValW-1:0]   rm_chain_o,
  output logic signed [plst_pkg::ValW-1:0]   last_chain_o
);

  // 1-based slot number of this cell
  localparam logic [CMPW-1:0] Slot = CMPW'(IDX + 1);

  logic signed [plst_pkg::ValW-1:0] value_q, value_d;
  logic                             at_pos, ahead;

  assign at_pos = (pos_i == Slot);
  assign ahead  = (Slot < pos_i);

  // Pick next entry: hold ahead of the position, else take new or neighbor
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins && !ahead) begin
      value_d = at_pos ? value_i : left_i;
    end else if (ctrl_i.rem && !ahead) begin
      value_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

  // Pass the removed entry and the new tail entry down the row
  assign rm_chain_o   = rm_chain_i | ((ctrl_i.rem && at_pos) ? value_q : '0);
  assign last_chain_o = last_chain_i | ((cnt_i == Slot) ? value_d : '0);

endmodule

@@ sv/positional_list_store_top.sv @@
// ----------------------------------------------------------------------------
// positional_list_store_top: bounded ordered list with insert/remove at index
// Row of storage cells with a registered result word.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command word (insert value at a 1-based position, or
//   remove at a position) on a valid/ready channel. Each accepted word gives
//   exactly one result word on out_o: status, removed value, count, and the
//   first and last entries after the operation.
//   The result is registered and valid in the cycle after the command is accepted.
//   Throughput: one word per cycle while results are read. Every cell compares
//   its own slot number against the position and shifts or holds in that same
//   cycle, so the row of CAPACITY cells settles a whole operation per clock.
//   The result sits in an output register; a new command is taken whenever
//   that register is empty or being read in the same cycle. While the
//   receiver stalls, the result holds and in_ready_o stays low.
//   Reset empties the list (count zero) and drops any pending result;
//   entry contents are not cleared and are never shown before written.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
  parameter int unsigned CAPACITY = plst_pkg::CapacityDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  plst_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output plst_pkg::out_t out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CntW > plst_pkg::PosW) ? CntW : plst_pkg::PosW) + 1;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 out_valid_q;
  plst_pkg::out_t       out_q, out_d;
  logic                 accept;
  logic [CmpW-1:0]      pos_ext, cnt_ext, cnt_new_ext;
  plst_pkg::status_e    status;
  plst_pkg::cell_ctrl_t ctrl;

  logic signed [plst_pkg::ValW-1:0] cell_val   [CAPACITY];
  logic signed [plst_pkg::ValW-1:0] rm_chain   [CAPACITY+1];
  logic signed [plst_pkg::ValW-1:0] last_chain [CAPACITY+1];
  logic signed [plst_pkg::ValW-1:0] first_val;

  // Take a word when the result register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext = CmpW'(in_i.position);
  assign cnt_ext = CmpW'(cnt_q);

  // Classify the command against the current fill
  always_comb begin
    status = plst_pkg::ST_OK;
    if (in_i.command == plst_pkg::CMD_INSERT) begin
      if (in_i.position == '0 || pos_ext > cnt_ext + CmpW'(1)) begin
        status = plst_pkg::ST_BADPOS;
      end else if (cnt_q == CntW'(CAPACITY)) begin
        status = plst_pkg::ST_FULL;
      end
    end else begin
      if (cnt_q == '0) begin
        status = plst_pkg::ST_EMPTY;
      end else if (in_i.position == '0 || pos_ext > cnt_ext) begin
        status = plst_pkg::ST_BADPOS;
      end
    end
  end

  assign ctrl.ins = accept && (in_i.command == plst_pkg::CMD_INSERT)
                    && (status == plst_pkg::ST_OK);
  assign ctrl.rem = accept && (in_i.command == plst_pkg::CMD_REMOVE)
                    && (status == plst_pkg::ST_OK);

  // Advance the fill count
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign cnt_new_ext = CmpW'(cnt_d);

  // Row of cells; chains start empty at the head
  assign rm_chain[0]   = '0;
  assign last_chain[0] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [plst_pkg::ValW-1:0] left_v, right_v;

    if (g == 0) begin : g_head
      assign left_v = in_i.value;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    plst_cell #(
      .IDX  (g),
      .CMPW (CmpW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos_ext),
      .cnt_i        (cnt_new_ext),
      .value_i      (in_i.value),
      .left_i       (left_v),
      .right_i      (right_v),
      .rm_chain_i   (rm_chain[g]),
      .last_chain_i (last_chain[g]),
      .value_o      (cell_val[g]),
      .rm_chain_o   (rm_chain[g+1]),
      .last_chain_o (last_chain[g+1])
    );
  end

  // Head entry after the operation
  always_comb begin
    first_val = cell_val[0];
    if (ctrl.ins && in_i.position == plst_pkg::PosW'(1)) begin
      first_val = in_i.value;
    end else if (ctrl.rem && in_i.position == plst_pkg::PosW'(1)) begin
      first_val = cell_val[1];
    end
    if (cnt_d == '0) begin
      first_val = '0;
    end
  end

  // Build the result word
  always_comb begin
    out_d.status        = status;
    out_d.removed_value = rm_chain[CAPACITY];
    out_d.count         = plst_pkg::CountW'(cnt_d);
    out_d.first_value   = first_val;
    out_d.last_value    = last_chain[CAPACITY];
  end

  // Hold the count and the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ sv/plst_checker.sv @@
// ----------------------------------------------------------------------------
// plst_checker: port-level checks for the positional list store
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module plst_checker #(
  parameter int unsigned CAPACITY = plst_pkg::CapacityDef
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input plst_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input plst_pkg::out_t out_o
);

  // A pending result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed while stalled");

  // Every accepted command shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted command gave no result");

  // Failed operations never report a removed entry
  a_no_removed_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != plst_pkg::ST_OK |-> out_o.removed_value == '0)
    else $error("removed value on failed operation");

  // An empty list shows zero head and tail
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.count == '0 |-> out_o.first_value == '0 && out_o.last_value == '0)
    else $error("nonzero head or tail on empty list");

  // Fill never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_o.count) <= CAPACITY)
    else $error("count above capacity");

endmodule

bind positional_list_store_top plst_checker #(.CAPACITY(CAPACITY)) u_plst_checker (.*);
